>>> hw/rtl/kpsd_pkg.sv
// Package with shared constants and types for the keypad scanner and debouncer.
`timescale 1ns / 1ps

package kpsd_pkg;

  // Matrix geometry.
  localparam int unsigned NumKeys = 16;
  localparam int unsigned NumRows = 4;
  localparam int unsigned NumCols = 4;

  // Default widths of the per-key counters.
  localparam int unsigned DebounceWidthDefault = 8;
  localparam int unsigned HoldWidthDefault     = 16;

  // Configuration register map.
  localparam int unsigned CfgAddrWidth  = 3;
  localparam logic [0:0]  RegDebounceMax = 1'b0;
  localparam logic [7:0]  DebounceMaxReset = 8'd5;

  // Width of the reported held time.
  localparam int unsigned HeldOutWidth = 16;

  // Last row of a scan.
  localparam logic [1:0] LastRow = 2'd3;

  // Status of all keys after an item, as handed from the key bank to the top level.
  typedef struct packed {
    logic [NumKeys-1:0] press_edges;
    logic [NumKeys-1:0] release_edges;
    logic [NumKeys-1:0] keys_down;
    logic [NumKeys-1:0] released_seen;
  } key_status_t;

endpackage

>>> hw/rtl/keypad_scan_debounce.sv
// Top level of the 4x4 keypad scanner with per-key debounce and held-time counters.
`timescale 1ns / 1ps

// Usage:
// Each input item on the slave stream carries the active-low column sample of the
// row now driven and the index of a key whose held time is wanted. Exactly one
// result item leaves on the master stream per input item. It gives the row to drive
// next, and the press and release edges, debounced key state, sticky released mask
// and queried held time; tlast marks the item that completed a four-row scan.
// The result is registered: an item accepted at one edge appears on the master side
// after that edge. Throughput is one item per cycle when not stalled, since all sixteen
// key updates are done in parallel in one level of logic between the state registers and
// the result register. s_axis_tready stays high while the result register is empty or
// being taken; when the receiver stalls, the result holds and the input stalls.
// Reset clears the row counter, scan word, all debounce and held-time counters,
// the key state and the released mask, and loads the press limit with 5.
// The press limit is written over the APB port at address 0.

module keypad_scan_debounce #(
  parameter int unsigned DEBOUNCE_WIDTH = kpsd_pkg::DebounceWidthDefault,
  parameter int unsigned HOLD_WIDTH     = kpsd_pkg::HoldWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [3:0] column_bits, [7:4] query_key
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic                              m_axis_tlast,  // scan_done
  // [1:0] drive_row, [17:2] press_edges, [33:18] release_edges, [49:34] keys_down,
  // [65:50] released_seen, [81:66] held_time, [87:82] zero
  output logic [87:0]                       m_axis_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kpsd_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [7:0]  debounce_max_q;
  logic [1:0]  row_q, row_d;
  logic [15:0] scan_q, scan_d;
  logic [15:0] scan_full;
  logic        accept, update;
  logic        hit;
  logic [1:0]  col_sel;
  logic [3:0]  column_bits, query_key;
  logic        out_valid_q;
  logic [87:0] out_data_q;
  logic        out_last_q;
  kpsd_pkg::key_status_t status;
  logic [kpsd_pkg::HeldOutWidth-1:0] held_time;

  assign column_bits = s_axis_tdata[3:0];
  assign query_key   = s_axis_tdata[7:4];

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_max_q <= kpsd_pkg::DebounceMaxReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == kpsd_pkg::RegDebounceMax)) begin
      debounce_max_q <= pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == kpsd_pkg::RegDebounceMax) ? {24'd0, debounce_max_q} : 32'd0;

  // Handshake: take an item whenever the result register is free or being taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign update        = accept && (row_q == kpsd_pkg::LastRow);

  // Lowest-numbered low column of the sampled row.
  always_comb begin
    hit     = 1'b0;
    col_sel = 2'd0;
    for (int c = kpsd_pkg::NumCols - 1; c >= 0; c--) begin
      if (!column_bits[c]) begin
        hit     = 1'b1;
        col_sel = 2'(c);
      end
    end
  end

  assign scan_full = scan_q | (hit ? (16'd1 << {row_q, col_sel}) : 16'd0);

  // Row counter and scan word advance on every accepted item.
  always_comb begin
    row_d  = row_q;
    scan_d = scan_q;
    if (accept) begin
      row_d  = row_q + 2'd1;
      scan_d = (row_q == kpsd_pkg::LastRow) ? 16'd0 : scan_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      scan_q <= '0;
    end else begin
      row_q  <= row_d;
      scan_q <= scan_d;
    end
  end

  // Per-key debounce and held-time state.
  kpsd_key_bank #(
    .DEBOUNCE_WIDTH(DEBOUNCE_WIDTH),
    .HOLD_WIDTH    (HOLD_WIDTH)
  ) u_key_bank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (update),
    .scan_word_i   (scan_full),
    .debounce_max_i(debounce_max_q),
    .query_key_i   (query_key),
    .status_o      (status),
    .held_time_o   (held_time)
  );

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_last_q <= update;
      out_data_q <= {6'd0, held_time, status.released_seen, status.keys_down,
                     status.release_edges, status.press_edges, row_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = out_data_q;

  // Edges only appear on the item that completes a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[33:2] == 32'd0))
    else $error("key edges reported outside a completed scan");

  // A completed scan always points back at row zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'd0)))
    else $error("scan done flag and next row disagree");

  // A pressed key is down and a released key is in the sticky mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (((m_axis_tdata[17:2] & ~m_axis_tdata[49:34]) == 16'd0) &&
                       ((m_axis_tdata[33:18] & ~m_axis_tdata[65:50]) == 16'd0)))
    else $error("key edge inconsistent with key state");

  // The sticky released mask never loses a bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((status.released_seen & $past(status.released_seen)) ==
                $past(status.released_seen)))
    else $error("released mask lost a bit");

endmodule

>>> hw/rtl/kpsd_key_bank.sv
// Per-key debounce counters, held-time counters and key state for all sixteen keys.
`timescale 1ns / 1ps

module kpsd_key_bank #(
  parameter int unsigned DEBOUNCE_WIDTH = kpsd_pkg::DebounceWidthDefault,
  parameter int unsigned HOLD_WIDTH     = kpsd_pkg::HoldWidthDefault
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     update_i,
  input  logic [kpsd_pkg::NumKeys-1:0]             scan_word_i,
  input  logic [7:0]                               debounce_max_i,
  input  logic [3:0]                               query_key_i,
  output kpsd_pkg::key_status_t                    status_o,
  output logic [kpsd_pkg::HeldOutWidth-1:0]        held_time_o
);

  localparam int unsigned LimWidth = (DEBOUNCE_WIDTH > 8) ? DEBOUNCE_WIDTH : 8;
  localparam logic [LimWidth-1:0] CntMax = LimWidth'((64'd1 << DEBOUNCE_WIDTH) - 64'd1);

  logic [DEBOUNCE_WIDTH-1:0] cnt_q    [kpsd_pkg::NumKeys];
  logic [DEBOUNCE_WIDTH-1:0] cnt_d    [kpsd_pkg::NumKeys];
  logic [HOLD_WIDTH-1:0]     hold_q   [kpsd_pkg::NumKeys];
  logic [HOLD_WIDTH-1:0]     hold_d   [kpsd_pkg::NumKeys];
  logic [kpsd_pkg::NumKeys-1:0] down_q, down_d;
  logic [kpsd_pkg::NumKeys-1:0] latch_q, latch_d;
  logic [kpsd_pkg::NumKeys-1:0] press, release_e;
  logic [LimWidth-1:0]       max_wide;
  logic [DEBOUNCE_WIDTH-1:0] lim;
  logic [HOLD_WIDTH-1:0]     held_sel;

  // The press limit saturates to the largest counter value.
  assign max_wide = LimWidth'(debounce_max_i);
  assign lim = (max_wide > CntMax) ? CntMax[DEBOUNCE_WIDTH-1:0]
                                   : max_wide[DEBOUNCE_WIDTH-1:0];

  // Each key moves one debounce step per completed scan, all keys in parallel.
  for (genvar k = 0; k < kpsd_pkg::NumKeys; k++) begin : g_key
    logic [DEBOUNCE_WIDTH-1:0] c_step;
    logic                      rel, down_mid, prs;
    logic [HOLD_WIDTH-1:0]     hold_mid;

    always_comb begin
      if (scan_word_i[k]) begin
        c_step = (cnt_q[k] < lim) ? cnt_q[k] + 1'b1 : cnt_q[k];
      end else begin
        c_step = (cnt_q[k] != '0) ? cnt_q[k] - 1'b1 : cnt_q[k];
      end
      // Release first, then held-time count, then press, as one scan update.
      rel      = (c_step == '0) && down_q[k];
      down_mid = down_q[k] && !rel;
      hold_mid = (down_mid && (hold_q[k] != '1)) ? hold_q[k] + 1'b1 : hold_q[k];
      prs      = (c_step == lim) && !down_mid;
    end

    // The key's state only moves when a scan completes.
    assign cnt_d[k]     = update_i ? c_step : cnt_q[k];
    assign press[k]     = update_i && prs;
    assign release_e[k] = update_i && rel;
    assign down_d[k]    = update_i ? (down_mid || prs) : down_q[k];
    assign latch_d[k]   = latch_q[k] || (update_i && rel);
    assign hold_d[k]    = !update_i ? hold_q[k] : (prs ? '0 : hold_mid);
  end

  // Key state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q  <= '0;
      latch_q <= '0;
      for (int k = 0; k < kpsd_pkg::NumKeys; k++) begin
        cnt_q[k]  <= '0;
        hold_q[k] <= '0;
      end
    end else begin
      down_q  <= down_d;
      latch_q <= latch_d;
      for (int k = 0; k < kpsd_pkg::NumKeys; k++) begin
        cnt_q[k]  <= cnt_d[k];
        hold_q[k] <= hold_d[k];
      end
    end
  end

  // Status after this item's update.
  assign status_o.press_edges   = press;
  assign status_o.release_edges = release_e;
  assign status_o.keys_down     = down_d;
  assign status_o.released_seen = latch_d;

  // Held time of the queried key, saturated to the reported width.
  assign held_sel = hold_d[query_key_i];

  if (HOLD_WIDTH > kpsd_pkg::HeldOutWidth) begin : g_held_sat
    assign held_time_o = (held_sel[HOLD_WIDTH-1:kpsd_pkg::HeldOutWidth] != '0)
                         ? '1 : held_sel[kpsd_pkg::HeldOutWidth-1:0];
  end else begin : g_held_ext
    assign held_time_o = kpsd_pkg::HeldOutWidth'(held_sel);
  end

endmodule
